// ===== src/csvp_pkg.sv =====
// Shared types, constants and keyword tables for the CSV access-log parser.
package csvp_pkg;

  localparam int MAX_LINE = 4096;
  localparam int LW       = $clog2(MAX_LINE + 2);
  localparam int HDR_LEN  = 66;
  localparam int HW       = $clog2(HDR_LEN + 1);
  localparam logic [63:0] HASH_SEED = 64'd5381;

  localparam logic [1:0] ST_VALID  = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_HEADER = 2'd2;
  localparam logic [1:0] ST_LONG   = 2'd3;

  localparam logic [8*HDR_LEN-1:0] HDR_TEXT =
    {"user_id,device", "_id,app_id,resource", "_id,event", "_type,location,timestamp"};

  typedef struct packed {
    logic [7:0] b;
    logic       eod;
    logic       is_nl;
    logic       is_comma;
    logic       is_cr;
    logic       is_digit;
    logic [3:0] digit;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [63:0]   fingerprint;
    logic [2:0]    event_code;
    logic [3:0]    location_code;
    logic [62:0]   timestamp;
    logic [LW-1:0] user_len;
    logic [LW-1:0] device_len;
    logic [LW-1:0] app_len;
    logic [LW-1:0] resource_len;
    logic [LW-1:0] line_length;
  } result_t;

  function automatic logic [7:0] hdr_char(input logic [HW-1:0] p);
    logic [7:0] c;
    c = 8'd0;
    for (int i = 0; i < HDR_LEN; i++) begin
      if (p == HW'(i)) c = HDR_TEXT[8*(HDR_LEN-1-i) +: 8];
    end
    return c;
  endfunction

  function automatic logic [3:0] ev_len(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      3'd0: n = 4'd5;
      3'd1: n = 4'd6;
      3'd2: n = 4'd13;
      3'd3: n = 4'd6;
      3'd4: n = 4'd12;
      3'd5: n = 4'd8;
      3'd6: n = 4'd8;
      default: n = 4'd12;
    endcase
    return n;
  endfunction

  function automatic logic [103:0] ev_word(input logic [2:0] k);
    logic [103:0] w;
    case (k)
      3'd0: w = "LOGIN";
      3'd1: w = "LOGOUT";
      3'd2: w = {"TOKEN_", "REFRESH"};
      3'd3: w = "ACCESS";
      3'd4: w = {"FAILED_", "LOGIN"};
      3'd5: w = {"OPEN_", "APP"};
      3'd6: w = "DOWNLOAD";
      default: w = {"ADMIN_", "ACTION"};
    endcase
    return w;
  endfunction

  // character p of event keyword k; p must be below its length
  function automatic logic [7:0] ev_char(input logic [2:0] k, input logic [3:0] p);
    logic [103:0] w;
    logic [3:0]   idx;
    w   = ev_word(k);
    idx = ev_len(k) - 4'd1 - p;
    return w[8*idx +: 8];
  endfunction

  function automatic logic [15:0] loc_word(input logic [3:0] k);
    logic [15:0] w;
    case (k)
      4'd0:  w = "US";
      4'd1:  w = "VN";
      4'd2:  w = "JP";
      4'd3:  w = "KR";
      4'd4:  w = "SG";
      4'd5:  w = "CN";
      4'd6:  w = "DE";
      4'd7:  w = "FR";
      4'd8:  w = "UK";
      4'd9:  w = "AU";
      4'd10: w = "CA";
      4'd11: w = "IN";
      4'd12: w = "BR";
      4'd13: w = "RU";
      default: w = "TH";
    endcase
    return w;
  endfunction

endpackage

// ===== src/csvp_front.sv =====
// Front end: accepts bytes, classifies them and queues them for the back end.
module csvp_front import csvp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_data,
  output logic       q_valid,
  output byte_item_t q_item,
  input  logic       q_take
);

  byte_item_t  mem [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  byte_item_t  cls;
  logic        do_push;

  always_comb begin
    cls.b        = data_byte;
    cls.eod      = end_of_data;
    cls.is_nl    = data_byte == 8'd10;
    cls.is_comma = data_byte == 8'h2C;
    cls.is_cr    = data_byte == 8'd13;
    cls.is_digit = data_byte >= 8'h30 && data_byte <= 8'h39;
    cls.digit    = 4'(data_byte - 8'h30);
  end

  assign full    = count == 3'd4;
  assign do_push = push && !full;
  assign q_valid = count != 3'd0;
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (q_take) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, do_push} - {2'b0, q_take};
    end
  end

endmodule

// ===== src/csvp_back.sv =====
// Back end: per-byte line state, field checks, hash and result assembly.
module csvp_back import csvp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  byte_item_t q_item,
  output logic       q_take,
  input  logic       out_full,
  output logic       out_push,
  output result_t    out_item
);

  logic [63:0]   hash;
  logic [2:0]    fidx;
  logic          too_many;
  logic [LW-1:0] flen;
  logic [LW-1:0] lcnt;
  logic [LW-1:0] idlen [4];
  logic [7:0]    evc;
  logic [14:0]   locc;
  logic [62:0]   ts;
  logic          bad;
  logic          crp;
  logic          hdrc;
  logic          first;

  logic [63:0]   hash_next;
  logic [2:0]    fidx_next;
  logic          too_many_next;
  logic [LW-1:0] flen_next;
  logic [LW-1:0] lcnt_next;
  logic [LW-1:0] idlen_next [4];
  logic [7:0]    evc_next;
  logic [14:0]   locc_next;
  logic [62:0]   ts_next;
  logic          bad_next;
  logic          crp_next;
  logic          hdrc_next;
  logic          first_next;

  logic [66:0]   ts10;
  logic          closing;
  logic          ok;
  logic [LW-1:0] ts_len;
  logic [2:0]    ev_idx;
  logic [3:0]    loc_idx;
  logic [15:0]   lw;
  logic [7:0]    b;

  assign q_take  = q_valid && !out_full;
  assign b       = q_item.b;
  assign closing = q_item.is_nl || q_item.eod;

  always_comb begin
    hash_next     = hash;
    fidx_next     = fidx;
    too_many_next = too_many;
    flen_next     = flen;
    lcnt_next     = lcnt;
    idlen_next    = idlen;
    evc_next      = evc;
    locc_next     = locc;
    ts_next       = ts;
    bad_next      = bad;
    crp_next      = crp;
    hdrc_next     = hdrc;
    ts10 = ({4'b0, ts} << 3) + ({4'b0, ts} << 1) + {63'b0, q_item.digit};
    lw = '0;

    if (!q_item.is_nl) begin
      hash_next = (hash << 5) + hash + {56'b0, b};
      if (lcnt < LW'(HDR_LEN)) begin
        if (b != hdr_char(HW'(lcnt))) hdrc_next = 1'b0;
      end else if (lcnt == LW'(HDR_LEN)) begin
        if (!q_item.is_cr) hdrc_next = 1'b0;
      end else begin
        hdrc_next = 1'b0;
      end
      if (lcnt <= LW'(MAX_LINE)) lcnt_next = lcnt + LW'(1);

      if (q_item.is_comma) begin
        if (fidx >= 3'd6) begin
          too_many_next = 1'b1;
        end else begin
          if (fidx < 3'd4) idlen_next[fidx[1:0]] = flen;
          else if (fidx == 3'd4) begin
            for (int k = 0; k < 8; k++)
              if (flen != LW'(ev_len(3'(k)))) evc_next[k] = 1'b0;
          end else if (flen != LW'(2)) locc_next = '0;
          fidx_next = fidx + 3'd1;
          flen_next = '0;
        end
      end else begin
        if (fidx == 3'd4) begin
          for (int k = 0; k < 8; k++) begin
            if (flen >= LW'(ev_len(3'(k)))) evc_next[k] = 1'b0;
            else if (b != ev_char(3'(k), flen[3:0])) evc_next[k] = 1'b0;
          end
        end else if (fidx == 3'd5) begin
          for (int k = 0; k < 15; k++) begin
            lw = loc_word(4'(k));
            if (flen >= LW'(2)) locc_next[k] = 1'b0;
            else if (b != (flen[0] ? lw[7:0] : lw[15:8])) locc_next[k] = 1'b0;
          end
        end else if (fidx == 3'd6) begin
          if (crp) bad_next = 1'b1;
          else if (q_item.is_cr) crp_next = 1'b1;
          else if (q_item.is_digit) begin
            if (!bad) begin
              if (ts10[66:63] != 4'b0) bad_next = 1'b1;
              else ts_next = ts10[62:0];
            end
          end else bad_next = 1'b1;
        end
        if (flen <= LW'(MAX_LINE)) flen_next = flen + LW'(1);
      end
    end
  end

  // result built from the post-byte state
  always_comb begin
    ev_idx  = '0;
    loc_idx = '0;
    for (int k = 7; k >= 0; k--) if (evc_next[k]) ev_idx = 3'(k);
    for (int k = 14; k >= 0; k--) if (locc_next[k]) loc_idx = 4'(k);
    ts_len = flen_next - {{(LW-1){1'b0}}, crp_next};
    ok = fidx_next == 3'd6 && !too_many_next && !bad_next && evc_next != '0 &&
         locc_next != '0 && ts_len != '0;
    for (int k = 0; k < 4; k++) if (idlen_next[k] == '0) ok = 1'b0;

    out_item = '0;
    out_item.line_length = (lcnt_next > LW'(MAX_LINE)) ? LW'(MAX_LINE) : lcnt_next;
    if (first && hdrc_next &&
        (lcnt_next == LW'(HDR_LEN) || lcnt_next == LW'(HDR_LEN + 1))) begin
      out_item.status = ST_HEADER;
    end else begin
      out_item.fingerprint = hash_next;
      if (lcnt_next > LW'(MAX_LINE)) out_item.status = ST_LONG;
      else if (!ok) out_item.status = ST_BAD;
      else begin
        out_item.status        = ST_VALID;
        out_item.event_code    = ev_idx;
        out_item.location_code = loc_idx;
        out_item.timestamp     = ts_next;
        out_item.user_len      = idlen_next[0];
        out_item.device_len    = idlen_next[1];
        out_item.app_len       = idlen_next[2];
        out_item.resource_len  = idlen_next[3];
      end
    end

    out_push   = q_take && closing && lcnt_next != '0;
    first_next = first;
    if (closing && lcnt_next != '0) first_next = 1'b0;
    if (q_item.eod) first_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash     <= HASH_SEED;
      fidx     <= '0;
      too_many <= 1'b0;
      flen     <= '0;
      lcnt     <= '0;
      for (int k = 0; k < 4; k++) idlen[k] <= '0;
      evc      <= '1;
      locc     <= '1;
      ts       <= '0;
      bad      <= 1'b0;
      crp      <= 1'b0;
      hdrc     <= 1'b1;
      first    <= 1'b1;
    end else if (q_take) begin
      first <= first_next;
      if (closing) begin
        hash     <= HASH_SEED;
        fidx     <= '0;
        too_many <= 1'b0;
        flen     <= '0;
        lcnt     <= '0;
        for (int k = 0; k < 4; k++) idlen[k] <= '0;
        evc      <= '1;
        locc     <= '1;
        ts       <= '0;
        bad      <= 1'b0;
        crp      <= 1'b0;
        hdrc     <= 1'b1;
      end else begin
        hash     <= hash_next;
        fidx     <= fidx_next;
        too_many <= too_many_next;
        flen     <= flen_next;
        lcnt     <= lcnt_next;
        idlen    <= idlen_next;
        evc      <= evc_next;
        locc     <= locc_next;
        ts       <= ts_next;
        bad      <= bad_next;
        crp      <= crp_next;
        hdrc     <= hdrc_next;
      end
    end
  end

endmodule

// ===== src/csvp_outq.sv =====
// Two-entry result queue between the back end and the result ports.
module csvp_outq import csvp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  result_t wr_item,
  output logic    q_full,
  output logic    empty,
  input  logic    pop,
  output result_t rd_item
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign q_full  = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, do_pop};
    end
  end

endmodule

// ===== src/csv_access_log_line_parser.sv =====
// Top level of the CSV access-log line parser.
// Usage:
//   Input channel: one log byte per item on data_byte, with end_of_data set on
//   the last byte of a file. An item is taken on a clock edge with push high
//   and full low.
//   Result channel: one item per closed non-empty line. While empty is low the
//   oldest result is on the result ports; pop with empty low takes it.
//   Lines close at a newline or at an end_of_data byte. The first non-empty
//   line of a file is reported as a skipped header if it matches the header.
//   Throughput: one byte per cycle while the result queue has room; the back
//   end updates hash, field checks and timestamp accumulate as it takes a byte.
//   Result path: a closing byte goes into the byte queue; the back end takes it
//   and writes its result into the result queue, whose head drives the ports.
//   Stalls: a stalled receiver fills the two-entry result queue, the back end
//   then holds, and the four-entry byte queue keeps taking bytes until full.
//   Reset (rst, synchronous) empties both queues and returns the line state
//   to the start of a new file.
module csv_access_log_line_parser import csvp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    data_byte,
  input  logic          end_of_data,
  output logic          empty,
  input  logic          pop,
  output logic [1:0]    status,
  output logic [63:0]   fingerprint,
  output logic [2:0]    event_code,
  output logic [3:0]    location_code,
  output logic [62:0]   timestamp,
  output logic [LW-1:0] user_len,
  output logic [LW-1:0] device_len,
  output logic [LW-1:0] app_len,
  output logic [LW-1:0] resource_len,
  output logic [LW-1:0] line_length
);

  byte_item_t q_item;
  logic       q_valid;
  logic       q_take;
  logic       oq_full;
  logic       res_push;
  result_t    res_item;
  result_t    head;

  csvp_front u_front (
    .clk, .rst, .push, .full, .data_byte, .end_of_data,
    .q_valid, .q_item, .q_take
  );

  csvp_back u_back (
    .clk, .rst, .q_valid, .q_item, .q_take,
    .out_full(oq_full), .out_push(res_push), .out_item(res_item)
  );

  csvp_outq u_outq (
    .clk, .rst, .wr(res_push), .wr_item(res_item), .q_full(oq_full),
    .empty, .pop, .rd_item(head)
  );

  assign status        = head.status;
  assign fingerprint   = head.fingerprint;
  assign event_code    = head.event_code;
  assign location_code = head.location_code;
  assign timestamp     = head.timestamp;
  assign user_len      = head.user_len;
  assign device_len    = head.device_len;
  assign app_len       = head.app_len;
  assign resource_len  = head.resource_len;
  assign line_length   = head.line_length;

endmodule
